// File: sv/bfcc_pkg.sv
package bfcc_pkg;

  localparam int INDEX_WIDTH  = 8;
  localparam int EXTENT_WIDTH = 10;
  localparam int CELLS_WIDTH  = 10;
  localparam int NODE_WIDTH   = 3;
  localparam int NODE_COUNT   = 4;
  localparam int NODES_WIDTH  = NODE_WIDTH * NODE_COUNT;
  localparam int FACE_COUNT   = 6;
  localparam int AXIS_COUNT   = 3;
  localparam logic [CELLS_WIDTH-1:0] CELLS_RESET = CELLS_WIDTH'(8);

  typedef logic [2:0]              face_t;
  typedef logic [1:0]              twist_t;
  typedef logic [NODES_WIDTH-1:0]  nodes_t;
  typedef logic [EXTENT_WIDTH-1:0] extent_t;
  typedef logic [CELLS_WIDTH-1:0]  cells_t;

  localparam face_t NO_FACE = 3'd6;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FIRST_NOT_FACE,
    ST_SECOND_NOT_FACE,
    ST_SELF_SAME_FACE,
    ST_BAD_TWIST,
    ST_EXTENT_MISMATCH
  } status_t;

  typedef enum logic [1:0] {
    REG_CELLS_X,
    REG_CELLS_Y,
    REG_CELLS_Z
  } reg_index_t;

  typedef struct packed {
    status_t status;
    face_t   first_face;
    face_t   second_face;
    twist_t  twist;
  } result_t;

  // corner numbers of each face: -x, +x, -y, +y, -z, +z
  localparam logic [NODE_WIDTH-1:0] FACE_CORNERS [FACE_COUNT][NODE_COUNT] = '{
    '{3'd0, 3'd4, 3'd7, 3'd3},
    '{3'd2, 3'd6, 3'd5, 3'd1},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd7, 3'd6, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd7, 3'd6, 3'd5, 3'd4}
  };

endpackage

// File: sv/bfcc_face_find.sv
module bfcc_face_find
  import bfcc_pkg::*;
(
  input  nodes_t nodes,
  output face_t  face
);

  // first face whose corner set holds every node
  always_comb begin
    logic all_in;
    logic hit;
    face = NO_FACE;
    for (int f = FACE_COUNT - 1; f >= 0; f--) begin
      all_in = 1'b1;
      for (int n = 0; n < NODE_COUNT; n++) begin
        hit = 1'b0;
        for (int k = 0; k < NODE_COUNT; k++) begin
          if (nodes[NODE_WIDTH*n +: NODE_WIDTH] == FACE_CORNERS[f][k]) begin
            hit = 1'b1;
          end
        end
        if (!hit) begin
          all_in = 1'b0;
        end
      end
      if (all_in) begin
        face = face_t'(f);
      end
    end
  end

endmodule

// File: sv/bfcc_judge.sv
module bfcc_judge
  import bfcc_pkg::*;
(
  input  logic    same_block,
  input  face_t   face_a,
  input  face_t   face_b,
  input  nodes_t  nodes_a,
  input  nodes_t  nodes_b,
  input  extent_t ext_a [AXIS_COUNT],
  input  extent_t ext_b [AXIS_COUNT],
  input  cells_t  cells_x,
  input  cells_t  cells_y,
  input  cells_t  cells_z,
  output result_t result
);

  function automatic twist_t corner_pos(face_t f, logic [NODE_WIDTH-1:0] c);
    twist_t pos;
    pos = '0;
    if (f < face_t'(FACE_COUNT)) begin
      for (int p = NODE_COUNT - 1; p >= 0; p--) begin
        if (FACE_CORNERS[f][p] == c) begin
          pos = twist_t'(p);
        end
      end
    end
    return pos;
  endfunction

  // msb set when the nodes disagree on the twist
  function automatic logic [2:0] twist_of(face_t fa, nodes_t a, face_t fb, nodes_t b);
    twist_t t;
    twist_t t0;
    logic   bad;
    t0  = corner_pos(fb, b[NODE_WIDTH-1:0]) - corner_pos(fa, a[NODE_WIDTH-1:0]);
    bad = 1'b0;
    for (int i = 1; i < NODE_COUNT; i++) begin
      t = corner_pos(fb, b[NODE_WIDTH*i +: NODE_WIDTH])
        - corner_pos(fa, a[NODE_WIDTH*i +: NODE_WIDTH]);
      if (t != t0) begin
        bad = 1'b1;
      end
    end
    return {bad, t0};
  endfunction

  nodes_t     nodes_b_rev;
  logic [2:0] tw_fwd;
  logic [2:0] tw_rev;
  logic       tw_bad;
  twist_t     tw;
  cells_t     n_a, n_b;
  extent_t    p1_a, p2_a, p1_b, p2_b;
  logic       ext_ok;

  assign nodes_b_rev = {nodes_b[2:0], nodes_b[5:3], nodes_b[8:6], nodes_b[11:9]};
  assign tw_fwd = twist_of(face_a, nodes_a, face_b, nodes_b);
  assign tw_rev = twist_of(face_a, nodes_a, face_b, nodes_b_rev);
  assign tw_bad = tw_fwd[2] && tw_rev[2];
  assign tw     = tw_fwd[2] ? tw_rev[1:0] : tw_fwd[1:0];

  always_comb begin
    case (face_a[2:1])
      2'd0: begin
        n_a = cells_x; p1_a = ext_a[1]; p2_a = ext_a[2];
      end
      2'd1: begin
        n_a = cells_y; p1_a = ext_a[2]; p2_a = ext_a[0];
      end
      default: begin
        n_a = cells_z; p1_a = ext_a[0]; p2_a = ext_a[1];
      end
    endcase
    case (face_b[2:1])
      2'd0: begin
        n_b = cells_x; p1_b = ext_b[1]; p2_b = ext_b[2];
      end
      2'd1: begin
        n_b = cells_y; p1_b = ext_b[2]; p2_b = ext_b[0];
      end
      default: begin
        n_b = cells_z; p1_b = ext_b[0]; p2_b = ext_b[1];
      end
    endcase
  end

  assign ext_ok = (n_a == n_b) &&
                  (tw[0] ? ((p1_a == p2_b) && (p2_a == p1_b))
                         : ((p1_a == p1_b) && (p2_a == p2_b)));

  always_comb begin
    result.status      = ST_OK;
    result.first_face  = face_a;
    result.second_face = face_b;
    result.twist       = '0;
    if (face_a == NO_FACE) begin
      result.status      = ST_FIRST_NOT_FACE;
      result.second_face = NO_FACE;
    end else if (face_b == NO_FACE) begin
      result.status = ST_SECOND_NOT_FACE;
    end else if (same_block && (face_a == face_b)) begin
      result.status = ST_SELF_SAME_FACE;
    end else if (tw_bad) begin
      result.status = ST_BAD_TWIST;
    end else begin
      result.twist  = tw;
      result.status = ext_ok ? ST_OK : ST_EXTENT_MISMATCH;
    end
  end

endmodule

// File: sv/block_face_connection_check.sv
// Checks whether two hexahedral blocks can be joined face to face. One item is
// taken per clock whenever start is high (busy never rises). The item sits in the
// input register while the face match and twist compare feed the result register,
// so the verdict is registered at the next clock edge and is held with done high
// for one cycle. The receiver cannot stall, so results must be taken as they come.
// cells_x/y/z are written through wr_en/wr_index/wr_data and should change
// only while no item is in flight.
module block_face_connection_check
  import bfcc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [INDEX_WIDTH-1:0]     first_block,
  input  logic [INDEX_WIDTH-1:0]     second_block,
  input  logic [NODES_WIDTH-1:0]     first_face_nodes,
  input  logic [NODES_WIDTH-1:0]     second_face_nodes,
  input  logic [EXTENT_WIDTH-1:0]    first_extent_x,
  input  logic [EXTENT_WIDTH-1:0]    first_extent_y,
  input  logic [EXTENT_WIDTH-1:0]    first_extent_z,
  input  logic [EXTENT_WIDTH-1:0]    second_extent_x,
  input  logic [EXTENT_WIDTH-1:0]    second_extent_y,
  input  logic [EXTENT_WIDTH-1:0]    second_extent_z,
  input  logic                       wr_en,
  input  logic [1:0]                 wr_index,
  input  logic [CELLS_WIDTH-1:0]     wr_data,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [2:0]                 first_face,
  output logic [2:0]                 second_face,
  output logic [1:0]                 twist
);

  cells_t  cells_x, cells_y, cells_z;
  logic    in_valid;
  logic    same_block;
  nodes_t  nodes_a, nodes_b;
  extent_t ext_a [AXIS_COUNT];
  extent_t ext_b [AXIS_COUNT];
  face_t   face_a, face_b;
  result_t res_next;
  result_t res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= CELLS_RESET;
      cells_y <= CELLS_RESET;
      cells_z <= CELLS_RESET;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_CELLS_X: cells_x <= wr_data;
        REG_CELLS_Y: cells_y <= wr_data;
        REG_CELLS_Z: cells_z <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      same_block <= (first_block == second_block);
      nodes_a    <= first_face_nodes;
      nodes_b    <= second_face_nodes;
      ext_a[0]   <= first_extent_x;
      ext_a[1]   <= first_extent_y;
      ext_a[2]   <= first_extent_z;
      ext_b[0]   <= second_extent_x;
      ext_b[1]   <= second_extent_y;
      ext_b[2]   <= second_extent_z;
    end
  end

  bfcc_face_find u_find_a (
    .nodes (nodes_a),
    .face  (face_a)
  );

  bfcc_face_find u_find_b (
    .nodes (nodes_b),
    .face  (face_b)
  );

  bfcc_judge u_judge (
    .same_block (same_block),
    .face_a     (face_a),
    .face_b     (face_b),
    .nodes_a    (nodes_a),
    .nodes_b    (nodes_b),
    .ext_a      (ext_a),
    .ext_b      (ext_b),
    .cells_x    (cells_x),
    .cells_y    (cells_y),
    .cells_z    (cells_z),
    .result     (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res <= res_next;
    end
  end

  assign status      = res.status;
  assign first_face  = res.first_face;
  assign second_face = res.second_face;
  assign twist       = res.twist;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start, 2)))
    else $error("done does not follow start by two cycles");

  a_ok_faces: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK)) |-> ((first_face != NO_FACE) && (second_face != NO_FACE)))
    else $error("ok verdict without two faces");

  a_no_first: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FIRST_NOT_FACE))
      |-> ((first_face == NO_FACE) && (second_face == NO_FACE) && (twist == 2'd0)))
    else $error("first-not-face verdict carries face or twist");

  a_self: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_SELF_SAME_FACE)) |-> (first_face == second_face))
    else $error("self-join verdict on different faces");

endmodule
